FILE: rtl/iomh_pkg.sv
// Shared types, sizes and opcodes for the I/O port mailbox hub.
// No dependencies; the files that use it refer to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package iomh_pkg;

   localparam int NUM_PORTS = 128;
   localparam int PORT_W    = $clog2(NUM_PORTS);
   localparam int DATA_W    = 32;
   localparam int DEV_W     = 8;
   localparam int OP_W      = 3;
   localparam int PORT_IN_W = 8;

   // Free-port search runs as a two-level tree: groups of GRP_SIZE ports.
   localparam int GRP_W    = 4;
   localparam int GRP_SIZE = 1 << GRP_W;
   localparam int NUM_GRP  = NUM_PORTS / GRP_SIZE;
   localparam int GSEL_W   = $clog2(NUM_GRP);

   // Request beat layout: opcode, port, data, device_id (lowest bit first).
   localparam int REQ_OP_LSB   = 0;
   localparam int REQ_PORT_LSB = REQ_OP_LSB + OP_W;
   localparam int REQ_DATA_LSB = REQ_PORT_LSB + PORT_IN_W;
   localparam int REQ_DEV_LSB  = REQ_DATA_LSB + DATA_W;
   localparam int REQ_BITS     = REQ_DEV_LSB + DEV_W;
   localparam int REQ_W        = ((REQ_BITS + 7) / 8) * 8;

   // Response beat: read_data, changed, ok, assigned_port, forward_valid,
   // forward_device, forward_data.
   localparam int RSP_BITS = DATA_W + 1 + 1 + 7 + 1 + DEV_W + DATA_W;
   localparam int RSP_W    = ((RSP_BITS + 7) / 8) * 8;

   localparam logic [OP_W-1:0] OP_QUERY     = 3'd0;
   localparam logic [OP_W-1:0] OP_CPU_READ  = 3'd1;
   localparam logic [OP_W-1:0] OP_CPU_WRITE = 3'd2;
   localparam logic [OP_W-1:0] OP_PLUG_FREE = 3'd3;
   localparam logic [OP_W-1:0] OP_PLUG_AT   = 3'd4;
   localparam logic [OP_W-1:0] OP_UNPLUG    = 3'd5;
   localparam logic [OP_W-1:0] OP_DEV_WRITE = 3'd6;

   // One port record as kept in the record RAM.
   typedef struct packed {
      logic [DEV_W-1:0]  dev_id;
      logic [DATA_W-1:0] dev_val;
      logic [DATA_W-1:0] cpu_val;
   } rec_type;

   localparam int REC_W = $bits(rec_type);

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic              changed;
      logic              ok;
      logic [6:0]        assigned_port;
      logic              fwd_valid;
      logic [DEV_W-1:0]  fwd_device;
      logic [DATA_W-1:0] fwd_data;
   } rsp_type;

   // Controller to datapath.
   typedef struct packed {
      logic accept;   // capture the request beat, read its port record
      logic commit;   // apply the update and load the response register
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic out_busy; // response register holds a beat that is not taken now
   } stat_type;

endpackage

`default_nettype wire

FILE: rtl/iomh_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module iomh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

FILE: rtl/iomh_ctrl.sv
// Two-state controller of the mailbox hub: capture a beat, then commit it.
// Depends on iomh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module iomh_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire iomh_pkg::stat_type stat,
   output iomh_pkg::cmd_type       cmd
);

   localparam logic [0:0] S_IDLE = 1'b0;
   localparam logic [0:0] S_EXEC = 1'b1;

   logic [0:0] state_ff;
   logic [0:0] state_in;

   assign req_tready = (state_ff == S_IDLE);
   assign cmd.accept = req_tready && req_tvalid;
   // hold in EXEC while the previous response is still stuck at the output
   assign cmd.commit = (state_ff == S_EXEC) && !stat.out_busy;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd.accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (cmd.commit) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/iomh_dpath.sv
// Datapath of the mailbox hub: port record RAM, flag vectors, free-port
// search tree and response register. Depends on iomh_pkg and iomh_ram.
`timescale 1ns / 1ps
`default_nettype none

module iomh_dpath (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire iomh_pkg::cmd_type            cmd,
   output iomh_pkg::stat_type                stat,
   input  wire logic [iomh_pkg::REQ_W-1:0]   req_tdata,
   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   output logic      [iomh_pkg::RSP_W-1:0]   rsp_tdata
);

   localparam int NP     = iomh_pkg::NUM_PORTS;
   localparam int PW     = iomh_pkg::PORT_W;
   localparam int DW     = iomh_pkg::DATA_W;
   localparam int VW     = iomh_pkg::DEV_W;
   localparam int NG     = iomh_pkg::NUM_GRP;
   localparam int GS     = iomh_pkg::GRP_SIZE;
   localparam int GW     = iomh_pkg::GRP_W;
   localparam int GSW    = iomh_pkg::GSEL_W;

   // captured request
   logic [iomh_pkg::OP_W-1:0] op_ff;
   logic [PW-1:0]             idx_ff;
   logic [DW-1:0]             data_ff;
   logic [VW-1:0]             dev_ff;
   logic [PW-1:0]             req_idx;

   // per-port flags; valid marks a record RAM entry written since reset
   logic [NP-1:0] occ_ff, occ_in;
   logic [NP-1:0] chg_ff, chg_in;
   logic [NP-1:0] vld_ff, vld_in;

   // free-port search tree, first level registered
   logic [NG-1:0] grp_free_ff, grp_free_in;
   logic [GW-1:0] grp_idx_ff [NG];
   logic [GW-1:0] grp_idx_in [NG];
   logic [GS-1:0] grp_vec;
   logic          ff_found;
   logic [GSW-1:0] ff_grp;
   logic [PW-1:0] ff_port;

   // record RAM
   iomh_pkg::rec_type rd_rec, cur_rec, wr_rec;
   logic              wr_en;
   logic [PW-1:0]     wr_addr;
   logic [PW-1:0]     rd_addr;

   iomh_pkg::rsp_type rsp_in;
   iomh_pkg::rsp_type rsp_ff;
   logic              rsp_valid_ff;

   logic cur_occ;
   logic cur_chg;

   // low bits of the port; the 0x7F mask and the wrap coincide at 128 ports
   assign req_idx = req_tdata[iomh_pkg::REQ_PORT_LSB +: PW];
   assign rd_addr = cmd.accept ? req_idx : idx_ff;

   iomh_ram #(
      .WIDTH(iomh_pkg::REC_W),
      .DEPTH(NP)
   ) u_rec_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_rec),
      .rd_addr(rd_addr),
      .rd_data(rd_rec)
   );

   // first level: lowest free port inside each group; port 0 never offered
   always_comb begin
      for (int g = 0; g < NG; g++) begin
         grp_vec = ~occ_ff[g*GS +: GS];
         if (g == 0) begin
            grp_vec[0] = 1'b0;
         end
         grp_free_in[g] = |grp_vec;
         grp_idx_in[g]  = '0;
         for (int b = GS - 1; b >= 0; b--) begin
            if (grp_vec[b]) begin
               grp_idx_in[g] = GW'(b);
            end
         end
      end
   end

   // second level: lowest group that has a free port
   always_comb begin
      ff_found = |grp_free_ff;
      ff_grp   = '0;
      for (int g = NG - 1; g >= 0; g--) begin
         if (grp_free_ff[g]) begin
            ff_grp = GSW'(g);
         end
      end
      ff_port = {ff_grp, grp_idx_ff[ff_grp]};
   end

   assign cur_occ = occ_ff[idx_ff];
   assign cur_chg = chg_ff[idx_ff];
   assign cur_rec = vld_ff[idx_ff] ? rd_rec : '0;

   assign stat.out_busy = rsp_valid_ff && !rsp_tready;

   always_comb begin
      rsp_in               = '0;
      rsp_in.changed       = cur_chg;
      wr_en                = 1'b0;
      wr_addr              = idx_ff;
      wr_rec               = cur_rec;
      occ_in               = occ_ff;
      chg_in               = chg_ff;
      vld_in               = vld_ff;
      unique case (op_ff)
         iomh_pkg::OP_QUERY: begin
         end
         iomh_pkg::OP_CPU_READ: begin
            rsp_in.read_data = cur_rec.dev_val;
            chg_in[idx_ff]   = 1'b0;
         end
         iomh_pkg::OP_CPU_WRITE: begin
            wr_en          = 1'b1;
            wr_rec.cpu_val = data_ff;
            if (cur_occ) begin
               rsp_in.fwd_valid  = 1'b1;
               rsp_in.fwd_device = cur_rec.dev_id;
               rsp_in.fwd_data   = data_ff;
            end
         end
         iomh_pkg::OP_PLUG_FREE: begin
            if (ff_found) begin
               wr_en                = 1'b1;
               wr_addr              = ff_port;
               wr_rec               = '0;
               wr_rec.dev_id        = dev_ff;
               occ_in[ff_port]      = 1'b1;
               rsp_in.ok            = 1'b1;
               rsp_in.assigned_port = 7'(ff_port);
            end
         end
         iomh_pkg::OP_PLUG_AT: begin
            if (!cur_occ) begin
               wr_en          = 1'b1;
               wr_rec         = '0;
               wr_rec.dev_id  = dev_ff;
               occ_in[idx_ff] = 1'b1;
               rsp_in.ok      = 1'b1;
            end
         end
         iomh_pkg::OP_UNPLUG: begin
            wr_en          = 1'b1;
            wr_rec         = '0;
            occ_in[idx_ff] = 1'b0;
         end
         iomh_pkg::OP_DEV_WRITE: begin
            wr_en          = 1'b1;
            wr_rec.dev_val = data_ff;
            chg_in[idx_ff] = 1'b1;
         end
         default: begin
         end
      endcase
      if (wr_en) begin
         vld_in[wr_addr] = 1'b1;
      end
      wr_en = wr_en && cmd.commit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         chg_ff       <= '0;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.commit) begin
            occ_ff       <= occ_in;
            chg_ff       <= chg_in;
            vld_ff       <= vld_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff   <= req_tdata[iomh_pkg::REQ_OP_LSB +: iomh_pkg::OP_W];
         idx_ff  <= req_idx;
         data_ff <= req_tdata[iomh_pkg::REQ_DATA_LSB +: DW];
         dev_ff  <= req_tdata[iomh_pkg::REQ_DEV_LSB +: VW];
      end
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
      grp_free_ff <= grp_free_in;
      for (int g = 0; g < NG; g++) begin
         grp_idx_ff[g] <= grp_idx_in[g];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   // fields from the lowest bit up, padded with zeros to whole bytes
   assign rsp_tdata = {
      (iomh_pkg::RSP_W - iomh_pkg::RSP_BITS)'(0),
      rsp_ff.fwd_data,
      rsp_ff.fwd_device,
      rsp_ff.fwd_valid,
      rsp_ff.assigned_port,
      rsp_ff.ok,
      rsp_ff.changed,
      rsp_ff.read_data
   };

endmodule

`default_nettype wire

FILE: rtl/io_port_mailbox_hub.sv
// I/O port mailbox hub: 128-port table between an emulated CPU and devices.
// Top level; depends on iomh_pkg, iomh_ctrl, iomh_dpath and iomh_ram.
//
// Usage:
//   Request channel (req_*): one beat per operation, carrying opcode, port,
//   data and device_id. Opcodes: query changed flag, CPU read, CPU write,
//   plug at first free port, plug at a given port, unplug, device write.
//   Only the low 7 bits of port select an entry.
//   Response channel (rsp_*): exactly one beat per request, in order, with
//   read data, changed flag, plug status, assigned port and the forwarded
//   CPU write (device id and value) when the port is occupied.
//   Sequencing: one request at a time, set by the read-then-write pass
//   over the port record RAM (read in the accept cycle, update at commit,
//   which waits while the output is busy); the commit loads the response
//   register that drives rsp_tvalid.
//   Reset: all flags clear at once; record RAM entries not yet written read
//   as zero through per-port valid bits, so no clearing pass is needed and
//   the block takes requests straight after reset.
//   Back-pressure: while rsp_tready is low the response beat holds; one
//   further request may be accepted and waits, fully computed, until the
//   response register frees up. req_tready stays low during that wait.
`timescale 1ns / 1ps
`default_nettype none

module io_port_mailbox_hub (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   // opcode[2:0], port[10:3], data[42:11], device_id[50:43], zero pad
   input  wire logic [iomh_pkg::REQ_W-1:0]  req_tdata,
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   // read_data[31:0], changed[32], ok[33], assigned_port[40:34],
   // forward_valid[41], forward_device[49:42], forward_data[81:50], zero pad
   output logic      [iomh_pkg::RSP_W-1:0]  rsp_tdata
);

   iomh_pkg::cmd_type  cmd;
   iomh_pkg::stat_type stat;

   // sequencing: IDLE takes a beat, EXEC commits it once the output is free
   iomh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // port table, free-port search and response register
   iomh_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

endmodule

`default_nettype wire

FILE: rtl/iomh_checker.sv
// Port-level checker for the mailbox hub, bound to the top level.
// Depends on iomh_pkg and io_port_mailbox_hub.
`timescale 1ns / 1ps
`default_nettype none

module iomh_checker (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_tvalid,
   input wire logic                       req_tready,
   input wire logic [iomh_pkg::REQ_W-1:0] req_tdata,
   input wire logic                       rsp_tvalid,
   input wire logic                       rsp_tready,
   input wire logic [iomh_pkg::RSP_W-1:0] rsp_tdata
);

   // hold a stalled response beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response beat changed");

   // one request in flight: no accept in the cycle after an accept
   a_req_spacing: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted on consecutive cycles");

   // a nonzero assigned port only comes with a successful plug
   a_assign_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[40:34] != 7'd0) |-> rsp_tdata[33])
      else $error("assigned port without ok");

   // no forwarded payload without forward_valid
   a_fwd_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[41] |-> rsp_tdata[81:42] == '0)
      else $error("forward fields set without forward_valid");

   // a response never appears without a prior request beat
   a_rsp_after_req: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tready))
      else $error("response without an accepted request");

endmodule

bind io_port_mailbox_hub iomh_checker u_iomh_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .req_tdata (req_tdata),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata)
);

`default_nettype wire
